@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// plain expression checked on every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

@@ hdl/rmdr_pkg.sv @@
// ---------------------------------------------------------------------------
// rmdr_pkg
// types and constants of the rational multiply / divide / reduce core
// ---------------------------------------------------------------------------
package rmdr_pkg;

  localparam int unsigned ResWidth = 64;
  localparam int unsigned CntWidth = 7;

  localparam logic [1:0] CMD_REDUCE = 2'd0;
  localparam logic [1:0] CMD_MUL    = 2'd1;
  localparam logic [1:0] CMD_DIV    = 2'd2;

  // datapath commands from the controller
  typedef struct packed {
    logic load;      // capture operands and command
    logic mul_start; // start 64 bit product on captured operands
    logic mul_step;  // one multiply step
    logic gcd_init;  // copy pair into gcd registers
    logic div_start; // start one truncated division
    logic div_step;  // one bit of division
    logic gcd_swap;  // x <= y, y <= remainder
    logic quo_num;   // store quotient as result numerator
    logic quo_den;   // store quotient as result denominator
    logic zero_den;  // special case of a zero denominator
    logic [1:0] div_sel; // dividend select: 0 x, 1 n, 2 d
  } rmdr_cmd_t;

  typedef struct packed {
    logic d_zero;
    logic y_zero;
    logic mul_done;
    logic div_done;
  } rmdr_sts_t;

endpackage

@@ hdl/rational_mul_div_reduce_core.sv @@
// ---------------------------------------------------------------------------
// rational_mul_div_reduce_core
// signed fraction reduce / multiply / divide with euclid gcd normalization
// ---------------------------------------------------------------------------
// channel  dir  tdata fields (low bit up)
// s_axis   in   cmd[1:0] a_num[33:2] a_den[65:34] b_num[97:66] b_den[129:98]
// m_axis   out  res_num[63:0] res_den[127:64]
//
// one request at a time: a multiply and a check of the denominator, which sends a
// zero denominator straight to the output, else the euclid loop on the shared one
// bit per cycle divider, then two divisions for the final quotients
// rst_ni clears the sequencer; the result stays on m_axis until taken
// ---------------------------------------------------------------------------
module rational_mul_div_reduce_core #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // cmd, a_num, a_den, b_num, b_den
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // res_num, res_den
);
  import rmdr_pkg::*;
  `include "assert_macros.svh"

  rmdr_cmd_t ctl;
  rmdr_sts_t sts;
  logic [63:0] res_num, res_den;
  logic [5:0] pad_unused;

  assign pad_unused = s_axis_tdata[135:130];

  rmdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (ctl),
    .sts_i       (sts)
  );

  rmdr_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk_i     (clk_i),
    .cmd_i     (s_axis_tdata[1:0]),
    .a_num_i   (s_axis_tdata[33:2]),
    .a_den_i   (s_axis_tdata[65:34]),
    .b_num_i   (s_axis_tdata[97:66]),
    .b_den_i   (s_axis_tdata[129:98]),
    .ctl_i     (ctl),
    .sts_o     (sts),
    .res_num_o (res_num),
    .res_den_o (res_den)
  );

  assign m_axis_tdata = {res_den, res_num};

  `ASSERT_ALWAYS(a_no_overlap, clk_i, rst_ni, !(s_axis_tready && m_axis_tvalid), "busy overlap")
  `ASSERT_IMPL(a_hold_out, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata), "result changed")
  `ASSERT_IMPL(a_one_div, clk_i, rst_ni, (ctl.div_start) |-> !ctl.div_step, "divider double command")

endmodule

@@ hdl/rmdr_ctrl.sv @@
// ---------------------------------------------------------------------------
// rmdr_ctrl
// sequencer: multiply, zero denominator check, euclid loop, two final divisions, output handshake
// ---------------------------------------------------------------------------
module rmdr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rmdr_pkg::rmdr_cmd_t cmd_o,
  input  rmdr_pkg::rmdr_sts_t sts_i
);
  import rmdr_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_GTEST  = 4'd3;
  localparam logic [3:0] S_GDIV   = 4'd4;
  localparam logic [3:0] S_NDIV   = 4'd5;
  localparam logic [3:0] S_DDIV   = 4'd6;
  localparam logic [3:0] S_OUT    = 4'd7;
  localparam logic [3:0] S_NSTART = 4'd8;
  localparam logic [3:0] S_DSTART = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load      = 1'b1;
          cmd_o.mul_start = 1'b1;
          state_d         = S_MUL;
        end
      end
      S_MUL: begin
        if (sts_i.mul_done) begin
          state_d = S_CHECK;
        end else begin
          cmd_o.mul_step = 1'b1;
        end
      end
      S_CHECK: begin
        if (sts_i.d_zero) begin
          cmd_o.zero_den = 1'b1;
          state_d        = S_OUT;
        end else begin
          cmd_o.gcd_init = 1'b1;
          state_d        = S_GTEST;
        end
      end
      S_GTEST: begin
        if (sts_i.y_zero) begin
          state_d = S_NSTART;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = 2'd0;
          state_d         = S_GDIV;
        end
      end
      S_GDIV: begin
        if (sts_i.div_done) begin
          cmd_o.gcd_swap = 1'b1;
          state_d        = S_GTEST;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_NSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 2'd1;
        state_d         = S_NDIV;
      end
      S_NDIV: begin
        if (sts_i.div_done) begin
          cmd_o.quo_num = 1'b1;
          state_d       = S_DSTART;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = 2'd2;
        state_d         = S_DDIV;
      end
      S_DDIV: begin
        if (sts_i.div_done) begin
          cmd_o.quo_den = 1'b1;
          state_d       = S_OUT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/rmdr_dp.sv @@
// ---------------------------------------------------------------------------
// rmdr_dp
// datapath: operand capture, 32x32 magnitude multiply, shared restoring divider
// ---------------------------------------------------------------------------
module rmdr_dp #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic [1:0]           cmd_i,
  input  logic [31:0]          a_num_i,
  input  logic [31:0]          a_den_i,
  input  logic [31:0]          b_num_i,
  input  logic [31:0]          b_den_i,
  input  rmdr_pkg::rmdr_cmd_t  ctl_i,
  output rmdr_pkg::rmdr_sts_t  sts_o,
  output logic [63:0]          res_num_o,
  output logic [63:0]          res_den_o
);
  import rmdr_pkg::*;

  localparam int unsigned W = ResWidth;

  function automatic logic [W-1:0] sext(input logic [31:0] v);
    logic [OPERAND_WIDTH-1:0] t;
    t = v[OPERAND_WIDTH-1:0];
    return {{(W-OPERAND_WIDTH){t[OPERAND_WIDTH-1]}}, t};
  endfunction

  logic [1:0]   op_q;
  logic [W-1:0] p0_q, p1_q, q0_q, q1_q; // factor pairs, sign extended
  logic [W-1:0] n_q, d_q, x_q, y_q;
  logic [W-1:0] rn_q, rd_q;
  logic         mstep_q;

  // multiply: unsigned magnitudes of at most 2^31 fit in 32 bits, one product each
  logic [31:0]  ma_q, mb_q; // n operands
  logic [31:0]  mc_q, md_q; // d operands
  logic [W-1:0] mn_acc_q, md_acc_q;
  logic         sn_q, sd_q;

  function automatic logic [W-1:0] absv(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [63:0] pp_n, pp_d;
  assign pp_n = {32'd0, ma_q} * {32'd0, mb_q};
  assign pp_d = {32'd0, mc_q} * {32'd0, md_q};

  logic mdone_q;

  // divider: truncated signed division by restoring, one bit a cycle
  logic [W-1:0] dq_q, dr_q, dv_q;
  logic         qneg_q, rneg_q;
  logic [CntWidth-1:0] dcnt_q;
  logic         dbusy_q;
  logic [W-1:0] dend, dsor;
  logic [W:0]   rtrial;
  logic [W-1:0] rshift;

  always_comb begin
    case (ctl_i.div_sel)
      2'd1:    dend = n_q;
      2'd2:    dend = d_q;
      default: dend = x_q;
    endcase
    dsor   = (ctl_i.div_sel == 2'd0) ? y_q : x_q;
    rshift = {dr_q[W-2:0], dq_q[W-1]};
    rtrial = {1'b0, rshift} - {1'b0, dv_q};
  end

  logic [W-1:0] quo_s, rem_s;
  assign quo_s = qneg_q ? (~dq_q + 1'b1) : dq_q;
  assign rem_s = rneg_q ? (~dr_q + 1'b1) : dr_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      op_q <= cmd_i;
      p0_q <= sext(a_num_i);
      p1_q <= sext(a_den_i);
      q0_q <= sext(b_num_i);
      q1_q <= sext(b_den_i);
    end
    if (ctl_i.mul_step) begin
      if (!mstep_q) begin
        // first cycle after load: choose factors
        case (op_q)
          CMD_MUL: begin
            ma_q <= 32'(absv(p0_q)); mb_q <= 32'(absv(q0_q));
            mc_q <= 32'(absv(p1_q)); md_q <= 32'(absv(q1_q));
            sn_q <= p0_q[W-1] ^ q0_q[W-1]; sd_q <= p1_q[W-1] ^ q1_q[W-1];
          end
          CMD_DIV: begin
            ma_q <= 32'(absv(p0_q)); mb_q <= 32'(absv(q1_q));
            mc_q <= 32'(absv(p1_q)); md_q <= 32'(absv(q0_q));
            sn_q <= p0_q[W-1] ^ q1_q[W-1]; sd_q <= p1_q[W-1] ^ q0_q[W-1];
          end
          default: begin
            ma_q <= 32'(absv(p0_q)); mb_q <= 32'd1;
            mc_q <= 32'(absv(p1_q)); md_q <= 32'd1;
            sn_q <= p0_q[W-1]; sd_q <= p1_q[W-1];
          end
        endcase
        mn_acc_q <= '0;
        md_acc_q <= '0;
        mstep_q  <= 1'b1;
        mdone_q  <= 1'b0;
      end else begin
        mn_acc_q <= pp_n;
        md_acc_q <= pp_d;
        mdone_q  <= 1'b1;
      end
    end
    if (ctl_i.mul_start) begin
      mstep_q <= 1'b0;
      mdone_q <= 1'b0;
    end
    if (ctl_i.gcd_init) begin
      x_q <= n_q;
      y_q <= d_q;
    end
    if (ctl_i.div_start) begin
      dq_q    <= absv(dend);
      dr_q    <= '0;
      dv_q    <= absv(dsor);
      qneg_q  <= dend[W-1] ^ dsor[W-1];
      rneg_q  <= dend[W-1];
      dcnt_q  <= '0;
      dbusy_q <= 1'b1;
    end else if (ctl_i.div_step) begin
      if (!rtrial[W]) begin
        dr_q <= rtrial[W-1:0];
        dq_q <= {dq_q[W-2:0], 1'b1};
      end else begin
        dr_q <= rshift;
        dq_q <= {dq_q[W-2:0], 1'b0};
      end
      dcnt_q <= dcnt_q + 1'b1;
      if (dcnt_q == CntWidth'(W - 1)) dbusy_q <= 1'b0;
    end
    if (ctl_i.gcd_swap) begin
      x_q <= y_q;
      y_q <= rem_s;
    end
    if (ctl_i.quo_num) rn_q <= quo_s;
    if (ctl_i.quo_den) rd_q <= quo_s;
    if (ctl_i.zero_den) begin
      rn_q <= (n_q != '0) ? 64'd1 : 64'd0;
      rd_q <= '0;
    end
  end

  // signed pair once the multiply has finished
  always_comb begin
    n_q = sn_q ? (~mn_acc_q + 1'b1) : mn_acc_q;
    d_q = sd_q ? (~md_acc_q + 1'b1) : md_acc_q;
  end

  assign sts_o.mul_done = mdone_q;
  assign sts_o.d_zero   = (d_q == '0);
  assign sts_o.y_zero   = (y_q == '0);
  assign sts_o.div_done = !dbusy_q;
  assign res_num_o      = rn_q;
  assign res_den_o      = rd_q;

endmodule

@@ tb/sv/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the rational reduce / multiply / divide core:
// directed corner fractions, then random requests, predicted in the bench
// with 64 bit arithmetic and a euclid gcd, checked in order at the output
// ---------------------------------------------------------------------------
module tb;
  import rmdr_pkg::*;

  localparam int unsigned OpWidth   = 32;
  localparam int unsigned NumRandom = 1600;
  localparam longint      MaxCycles = 64'd60_000_000;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
    bit          hold; // wait for all results before presenting
  } frac_req_t;

  typedef struct {
    logic signed [63:0] num;
    logic signed [63:0] den;
  } frac_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  frac_req_t pending_reqs[$];
  frac_res_t expected_fracs[$];
  int        num_errors = 0;
  int        num_checked = 0;
  int        cmd_seen[4];
  longint    cycle_cnt = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  bit        stim_done = 1'b0;

  rational_mul_div_reduce_core #(.OPERAND_WIDTH(OpWidth)) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),  // cmd, a_num, a_den, b_num, b_den
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)   // res_num, res_den
  );

  always #5 clk_i = ~clk_i;

  function automatic frac_res_t reduce_fraction(logic [135:0] data);
    logic [1:0]         cmd;
    logic signed [63:0] an, ad, bn, bd, n, d, x, y, t;
    frac_res_t          r;
    cmd = data[1:0];
    an  = 64'(signed'(data[33:2]));
    ad  = 64'(signed'(data[65:34]));
    bn  = 64'(signed'(data[97:66]));
    bd  = 64'(signed'(data[129:98]));
    if (cmd == CMD_MUL) begin
      n = an * bn;
      d = ad * bd;
    end else if (cmd == CMD_DIV) begin
      n = an * bd;
      d = ad * bn;
    end else begin
      n = an;
      d = ad;
    end
    if (d == 0) begin
      if (n != 0) n = 1;
    end else begin
      // truncated remainder, gcd sign left as the loop gives it
      x = n;
      y = d;
      while (y != 0) begin
        t = y;
        y = x % y;
        x = t;
      end
      n = n / x;
      d = d / x;
    end
    r.num = n;
    r.den = d;
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'(signed'($urandom_range(0, 40)) - 20);
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
      3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return 32'(signed'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  task automatic add_req(logic [1:0] cmd, logic [31:0] an, logic [31:0] ad,
                         logic [31:0] bn, logic [31:0] bd, bit hold);
    frac_req_t r;
    r.cmd = cmd; r.a_num = an; r.a_den = ad; r.b_num = bn; r.b_den = bd;
    r.hold = hold;
    pending_reqs.push_back(r);
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    num_errors++;
    $display("mismatch %0s: got %0d expected %0d", what, signed'(got), signed'(exp));
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_fracs.push_back(reduce_fraction(s_axis_tdata));
        cmd_seen[s_axis_tdata[1:0]]++;
        send_gap = pick_gap();
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !(pending_reqs[0].hold &&
                     (expected_fracs.size() > 0 || s_axis_tvalid))) begin
          frac_req_t r;
          r = pending_reqs.pop_front();
          s_axis_tdata  <= {6'd0, r.b_den, r.b_num, r.a_den, r.a_num, r.cmd};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_fracs.size() == 0) begin
          num_errors++;
          $display("unexpected result num %0d den %0d",
                   signed'(m_axis_tdata[63:0]), signed'(m_axis_tdata[127:64]));
        end else begin
          frac_res_t e;
          e = expected_fracs.pop_front();
          num_checked++;
          if (m_axis_tdata[63:0] !== e.num) report_mismatch("res_num", m_axis_tdata[63:0], e.num);
          if (m_axis_tdata[127:64] !== e.den)
            report_mismatch("res_den", m_axis_tdata[127:64], e.den);
        end
        recv_gap = pick_gap();
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > MaxCycles) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_fracs.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [1:0] c;
    // directed corners
    add_req(CMD_REDUCE, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0);
    add_req(CMD_REDUCE, 32'd5, 32'd0, 32'd0, 32'd0, 1'b0);
    add_req(CMD_REDUCE, -32'sd7, 32'd0, 32'd1, 32'd1, 1'b0);
    add_req(CMD_REDUCE, 32'd0, 32'd7, 32'd0, 32'd0, 1'b0);
    add_req(CMD_REDUCE, 32'd6, -32'sd4, 32'd0, 32'd0, 1'b0);
    add_req(CMD_REDUCE, -32'sd6, 32'd4, 32'd0, 32'd0, 1'b0);
    add_req(CMD_REDUCE, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    add_req(CMD_REDUCE, 32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'd0, 1'b0);
    add_req(CMD_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    add_req(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    add_req(CMD_MUL, 32'd3, 32'd4, 32'd8, 32'd9, 1'b0);
    add_req(CMD_MUL, 32'd3, 32'd0, 32'd0, 32'd9, 1'b0);
    add_req(CMD_MUL, 32'd3, 32'd5, 32'd2, 32'd0, 1'b0);
    add_req(CMD_MUL, 32'd0, 32'd5, 32'd2, 32'd7, 1'b0);
    add_req(CMD_DIV, 32'd3, 32'd4, 32'd9, 32'd8, 1'b0);
    add_req(CMD_DIV, 32'd3, 32'd4, 32'd0, 32'd8, 1'b0);
    add_req(CMD_DIV, 32'd0, 32'd4, 32'd0, 32'd8, 1'b0);
    add_req(CMD_DIV, 32'h8000_0000, -32'sd1, 32'h8000_0000, -32'sd1, 1'b0);
    add_req(CMD_DIV, -32'sd10, 32'd6, 32'd15, -32'sd4, 1'b0);
    add_req(2'd3, 32'd12, 32'd18, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    add_req(2'd3, 32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd0, 1'b1);
    for (int i = 0; i < NumRandom; i++) begin
      c = (i % 50 == 49) ? 2'd3 : 2'($urandom_range(0, 2));
      add_req(c, rand_operand(), rand_operand(), rand_operand(), rand_operand(),
              i % 400 == 200);
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() == 0);
    @(posedge clk_i);
    while (s_axis_tvalid || expected_fracs.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("checked %0d results: reduce %0d, multiply %0d, divide %0d, unused code %0d",
             num_checked, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
    $display("including zero denominators, extreme operands and negative gcd signs");
    if (num_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
